>>> hdl/sfp_pkg.sv
// Shared types and constants for the sensor frame parser.
package sfp_pkg;

  localparam int unsigned ByteW         = 8;
  localparam int unsigned LenW          = 7;
  localparam int unsigned IdxW          = 6;
  localparam int unsigned MaxPayloadDef = 64;
  localparam int unsigned QueueDepth    = 2;
  localparam logic [ByteW-1:0] HeaderReset = 8'hEF;

  // Header fields of one checked frame, handed from the parser to the drain side.
  typedef struct packed {
    logic [ByteW-1:0] device_id;
    logic [ByteW-1:0] system_id;
    logic [ByteW-1:0] message_id;
    logic [ByteW-1:0] sequence_res;
    logic [LenW-1:0]  payload_length;
  } frame_desc_t;

endpackage

>>> hdl/sensor_frame_parser_sum8_top.sv
// Input words are taken one per cycle, except that payload words wait while an earlier frame
// drains and a checksum word waits while two checked frames are already queued.
// A good checksum word pushes the frame's header into the queue; the drain side pops it when idle and,
// unless the frame is empty, reads each payload word from the store before showing it as an output word.
// Reset clears all control state and sets the header byte to 0xEF; the store needs no clearing.
module sensor_frame_parser_sum8_top #(
  parameter int unsigned MaxPayload = sfp_pkg::MaxPayloadDef
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [sfp_pkg::ByteW-1:0] cfg_wdata_i,
  input  logic [sfp_pkg::ByteW-1:0] rx_byte_i,
  input  logic                      rx_valid_i,
  output logic                      rx_stall_o,
  output logic [sfp_pkg::ByteW-1:0] device_id_o,
  output logic [sfp_pkg::ByteW-1:0] system_id_o,
  output logic [sfp_pkg::ByteW-1:0] message_id_o,
  output logic [sfp_pkg::ByteW-1:0] sequence_res_o,
  output logic [sfp_pkg::LenW-1:0]  payload_length_o,
  output logic [sfp_pkg::IdxW-1:0]  byte_index_o,
  output logic [sfp_pkg::ByteW-1:0] payload_byte_o,
  output logic                      last_o,
  output logic                      out_valid_o,
  input  logic                      out_stall_i
);
  import sfp_pkg::*;

  localparam int unsigned AddrW = (MaxPayload > 1) ? $clog2(MaxPayload) : 1;

  frame_desc_t      push_desc, pop_desc;
  logic             push, pop, q_empty, q_full, back_busy, drain_busy;
  logic             ram_we, ram_re;
  logic [AddrW-1:0] ram_waddr, ram_raddr;
  logic [ByteW-1:0] ram_wdata, ram_rdata;

  assign drain_busy = back_busy || !q_empty;

  sfp_front #(.MaxPayload(MaxPayload), .AddrW(AddrW)) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .rx_byte_i    (rx_byte_i),
    .rx_valid_i   (rx_valid_i),
    .rx_stall_o   (rx_stall_o),
    .drain_busy_i (drain_busy),
    .queue_full_i (q_full),
    .push_o       (push),
    .desc_o       (push_desc),
    .ram_we_o     (ram_we),
    .ram_waddr_o  (ram_waddr),
    .ram_wdata_o  (ram_wdata)
  );

  sfp_queue #(.Depth(QueueDepth)) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .desc_i  (push_desc),
    .pop_i   (pop),
    .desc_o  (pop_desc),
    .empty_o (q_empty),
    .full_o  (q_full)
  );

  sfp_ram #(.Width(ByteW), .Depth(MaxPayload), .AddrW(AddrW)) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  sfp_back #(.MaxPayload(MaxPayload), .AddrW(AddrW)) u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .q_empty_i        (q_empty),
    .q_desc_i         (pop_desc),
    .q_pop_o          (pop),
    .busy_o           (back_busy),
    .ram_re_o         (ram_re),
    .ram_raddr_o      (ram_raddr),
    .ram_rdata_i      (ram_rdata),
    .device_id_o      (device_id_o),
    .system_id_o      (system_id_o),
    .message_id_o     (message_id_o),
    .sequence_res_o   (sequence_res_o),
    .payload_length_o (payload_length_o),
    .byte_index_o     (byte_index_o),
    .payload_byte_o   (payload_byte_o),
    .last_o           (last_o),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i)
  );

endmodule

>>> hdl/sfp_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
module sfp_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 64,
  parameter int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> hdl/sfp_front.sv
// Frame parser: walks the header, stores the payload and checks the sum.
module sfp_front #(
  parameter int unsigned MaxPayload = sfp_pkg::MaxPayloadDef,
  parameter int unsigned AddrW      = (MaxPayload > 1) ? $clog2(MaxPayload) : 1
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [sfp_pkg::ByteW-1:0] cfg_wdata_i,
  input  logic [sfp_pkg::ByteW-1:0] rx_byte_i,
  input  logic                      rx_valid_i,
  output logic                      rx_stall_o,
  input  logic                      drain_busy_i,
  input  logic                      queue_full_i,
  output logic                      push_o,
  output sfp_pkg::frame_desc_t      desc_o,
  output logic                      ram_we_o,
  output logic [AddrW-1:0]          ram_waddr_o,
  output logic [sfp_pkg::ByteW-1:0] ram_wdata_o
);
  import sfp_pkg::*;

  typedef enum logic [2:0] {
    PH_HUNT, PH_DEVICE, PH_SYSTEM, PH_MESSAGE, PH_SEQUENCE, PH_LENGTH, PH_PAYLOAD, PH_CHECK
  } phase_e;

  phase_e           phase_q;
  logic [ByteW-1:0] header_q;
  logic [ByteW-1:0] device_q, system_q, message_q, sequence_q;
  logic [LenW-1:0]  length_q;
  logic [LenW-1:0]  count_q;
  logic [ByteW-1:0] sum_q;
  logic             accept;
  logic [ByteW-1:0] sum_next;
  logic [LenW-1:0]  count_next;

  // Payload writes must wait until the previous frame has left the store.
  assign rx_stall_o = ((phase_q == PH_PAYLOAD) && drain_busy_i) ||
                      ((phase_q == PH_CHECK) && queue_full_i);
  assign accept     = rx_valid_i && !rx_stall_o;
  assign sum_next   = sum_q + rx_byte_i;
  assign count_next = count_q + LenW'(1);

  assign push_o = accept && (phase_q == PH_CHECK) && (rx_byte_i == sum_q);
  assign desc_o = '{device_id: device_q, system_id: system_q, message_id: message_q,
                    sequence_res: sequence_q, payload_length: length_q};

  assign ram_we_o    = accept && (phase_q == PH_PAYLOAD);
  assign ram_waddr_o = count_q[AddrW-1:0];
  assign ram_wdata_o = rx_byte_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PH_HUNT;
      header_q   <= HeaderReset;
      device_q   <= '0;
      system_q   <= '0;
      message_q  <= '0;
      sequence_q <= '0;
      length_q   <= '0;
      count_q    <= '0;
      sum_q      <= '0;
    end else begin
      if (cfg_we_i) begin
        header_q <= cfg_wdata_i;
      end
      if (accept) begin
        unique case (phase_q)
          PH_HUNT: begin
            if (rx_byte_i == header_q) begin
              sum_q   <= rx_byte_i;
              phase_q <= PH_DEVICE;
            end
          end
          PH_DEVICE: begin
            device_q <= rx_byte_i;
            sum_q    <= sum_next;
            phase_q  <= PH_SYSTEM;
          end
          PH_SYSTEM: begin
            system_q <= rx_byte_i;
            sum_q    <= sum_next;
            phase_q  <= PH_MESSAGE;
          end
          PH_MESSAGE: begin
            message_q <= rx_byte_i;
            sum_q     <= sum_next;
            phase_q   <= PH_SEQUENCE;
          end
          PH_SEQUENCE: begin
            sequence_q <= rx_byte_i;
            sum_q      <= sum_next;
            phase_q    <= PH_LENGTH;
          end
          PH_LENGTH: begin
            count_q <= '0;
            sum_q   <= sum_next;
            if (rx_byte_i == '0) begin
              length_q <= '0;
              phase_q  <= PH_CHECK;
            end else if (rx_byte_i > ByteW'(MaxPayload)) begin
              phase_q <= PH_HUNT;
            end else begin
              length_q <= rx_byte_i[LenW-1:0];
              phase_q  <= PH_PAYLOAD;
            end
          end
          PH_PAYLOAD: begin
            sum_q <= sum_next;
            if (count_next >= length_q) begin
              count_q <= '0;
              phase_q <= PH_CHECK;
            end else begin
              count_q <= count_next;
            end
          end
          PH_CHECK: begin
            phase_q <= PH_HUNT;
          end
          default: phase_q <= PH_HUNT;
        endcase
      end
    end
  end

endmodule

>>> hdl/sfp_queue.sv
// Small FIFO of checked frame headers between the parser and the drain side.
module sfp_queue #(
  parameter int unsigned Depth = sfp_pkg::QueueDepth
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  input  sfp_pkg::frame_desc_t desc_i,
  input  logic                 pop_i,
  output sfp_pkg::frame_desc_t desc_o,
  output logic                 empty_o,
  output logic                 full_o
);
  import sfp_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  frame_desc_t     entry_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] count_q;
  logic            do_push, do_pop;

  assign empty_o = (count_q == '0);
  assign full_o  = (count_q == CntW'(Depth));
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign desc_o  = entry_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wr_ptr_q] <= desc_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + CntW'(1);
      end else if (do_pop && !do_push) begin
        count_q <= count_q - CntW'(1);
      end
    end
  end

endmodule

>>> hdl/sfp_back.sv
// Drain side: reads a stored payload back and sends one word per byte (one word for an empty frame).
module sfp_back #(
  parameter int unsigned MaxPayload = sfp_pkg::MaxPayloadDef,
  parameter int unsigned AddrW      = (MaxPayload > 1) ? $clog2(MaxPayload) : 1
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      q_empty_i,
  input  sfp_pkg::frame_desc_t      q_desc_i,
  output logic                      q_pop_o,
  output logic                      busy_o,
  output logic                      ram_re_o,
  output logic [AddrW-1:0]          ram_raddr_o,
  input  logic [sfp_pkg::ByteW-1:0] ram_rdata_i,
  output logic [sfp_pkg::ByteW-1:0] device_id_o,
  output logic [sfp_pkg::ByteW-1:0] system_id_o,
  output logic [sfp_pkg::ByteW-1:0] message_id_o,
  output logic [sfp_pkg::ByteW-1:0] sequence_res_o,
  output logic [sfp_pkg::LenW-1:0]  payload_length_o,
  output logic [sfp_pkg::IdxW-1:0]  byte_index_o,
  output logic [sfp_pkg::ByteW-1:0] payload_byte_o,
  output logic                      last_o,
  output logic                      out_valid_o,
  input  logic                      out_stall_i
);
  import sfp_pkg::*;

  typedef enum logic [1:0] {ST_IDLE, ST_READ, ST_SHOW} state_e;

  state_e           state_q;
  frame_desc_t      desc_q;
  logic [IdxW-1:0]  idx_q;
  logic [ByteW-1:0] byte_q;
  logic             last_q;
  logic             start;
  logic             advance;
  logic [IdxW-1:0]  idx_next;

  assign start    = (state_q == ST_IDLE) && !q_empty_i;
  assign advance  = (state_q == ST_SHOW) && !out_stall_i && !last_q;
  assign idx_next = idx_q + IdxW'(1);

  assign q_pop_o     = start;
  assign busy_o      = (state_q != ST_IDLE);
  assign ram_re_o    = start || advance;
  assign ram_raddr_o = start ? '0 : idx_next[AddrW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      desc_q  <= '0;
      idx_q   <= '0;
      byte_q  <= '0;
      last_q  <= 1'b0;
    end else begin
      unique case (state_q)
        ST_IDLE: begin
          if (start) begin
            desc_q <= q_desc_i;
            idx_q  <= '0;
            if (q_desc_i.payload_length == '0) begin
              // An empty frame still yields one word carrying its header.
              byte_q  <= '0;
              last_q  <= 1'b1;
              state_q <= ST_SHOW;
            end else begin
              state_q <= ST_READ;
            end
          end
        end
        ST_READ: begin
          byte_q  <= ram_rdata_i;
          last_q  <= ({1'b0, idx_q} + LenW'(1)) == desc_q.payload_length;
          state_q <= ST_SHOW;
        end
        ST_SHOW: begin
          if (!out_stall_i) begin
            if (last_q) begin
              state_q <= ST_IDLE;
            end else begin
              idx_q   <= idx_next;
              state_q <= ST_READ;
            end
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign device_id_o      = desc_q.device_id;
  assign system_id_o      = desc_q.system_id;
  assign message_id_o     = desc_q.message_id;
  assign sequence_res_o   = desc_q.sequence_res;
  assign payload_length_o = desc_q.payload_length;
  assign byte_index_o     = idx_q;
  assign payload_byte_o   = byte_q;
  assign last_o           = last_q;
  assign out_valid_o      = (state_q == ST_SHOW);

endmodule
